// File: rtl/ncsl_pkg.sv
`default_nettype none
package ncsl_pkg;

  localparam int PROB_FRAC_BITS = 16;
  localparam int WF             = 30;
  localparam int QDEPTH         = 2;
  localparam int QPTR_W         = $clog2(QDEPTH);
  localparam int DIV_NW         = 72;
  localparam int DIV_DW         = 32;
  localparam int DIV_CW         = 7;

  localparam logic [30:0] ONE_Q30 = 31'd1 << WF;

  localparam logic [27:0] COEF_B0 =
    28'(((64'd231641900 << WF) + 64'd500000000) / 64'd1000000000);
  localparam logic [33:0] COEF_B1_MAG =
    34'(((64'd319381530 << WF) + 64'd500000000) / 64'd1000000000);
  localparam logic [33:0] COEF_B2_MAG =
    34'(((64'd356563782 << WF) + 64'd500000000) / 64'd1000000000);
  localparam logic [33:0] COEF_B3_MAG =
    34'(((64'd1781477937 << WF) + 64'd500000000) / 64'd1000000000);
  localparam logic [33:0] COEF_B4_MAG =
    34'(((64'd1821255978 << WF) + 64'd500000000) / 64'd1000000000);
  localparam logic [33:0] COEF_B5_MAG =
    34'(((64'd1330274429 << WF) + 64'd500000000) / 64'd1000000000);
  localparam logic [28:0] INV_SQRT_2PI =
    29'(((64'd398942280 << WF) + 64'd500000000) / 64'd1000000000);
  localparam logic [29:0] LN2_Q30 = 30'd744261118;

  localparam logic [23:0] XQ_SAT = 24'd8 << 20;

  typedef struct packed {
    logic [15:0] job_mean;
    logic [15:0] job_variance;
    logic        job_present;
    logic        machine_last;
    logic        schedule_last;
  } in_item_t;

  typedef struct packed {
    logic [16:0] service_level;
    logic [15:0] machines_counted;
  } out_item_t;

  typedef struct packed {
    logic        close;
    logic        emit;
    logic [16:0] d;
    logic [15:0] var_sum;
  } close_req_t;

  typedef struct packed {
    logic                start;
    logic [DIV_NW-1:0]   num;
    logic [DIV_DW-1:0]   den;
    logic [DIV_CW-1:0]   nbits;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [DIV_NW-1:0]   quo;
  } div_rsp_t;

  typedef enum logic [4:0] {
    B_IDLE, B_CHK, B_DD, B_QDIV, B_SQRT, B_DEN, B_DEN2, B_TDIV,
    B_PM, B_PA, B_UM, B_UD, B_KDIV, B_EM, B_EA, B_ED, B_ESH,
    B_PHM, B_PHA, B_TLM, B_TLA, B_P16, B_PROD, B_EMIT
  } back_state_t;

  // polynomial coefficient for step idx; idx 0 is the final multiply only
  function automatic logic signed [33:0] coef(input logic [2:0] idx);
    logic signed [33:0] c;
    begin
      case (idx)
        3'd1:    c = COEF_B1_MAG;
        3'd2:    c = 34'd0 - COEF_B2_MAG;
        3'd3:    c = COEF_B3_MAG;
        3'd4:    c = 34'd0 - COEF_B4_MAG;
        3'd5:    c = COEF_B5_MAG;
        default: c = '0;
      endcase
      return c;
    end
  endfunction

  function automatic logic [16:0] to_q16(input logic [30:0] p30);
    logic [31:0] p;
    begin
      p = {1'b0, p30};
      if (WF > PROB_FRAC_BITS)
        p = (p + (32'd1 << (WF - PROB_FRAC_BITS - 1))) >> (WF - PROB_FRAC_BITS);
      if (PROB_FRAC_BITS > 16)
        p = (p + (32'd1 << (PROB_FRAC_BITS - 17))) >> (PROB_FRAC_BITS - 16);
      else if (PROB_FRAC_BITS < 16)
        p = p << (16 - PROB_FRAC_BITS);
      return p[16:0];
    end
  endfunction

endpackage
`default_nettype wire

// File: rtl/normal_cdf_service_level_top.sv
// Normal-CDF service level of a machine schedule.
// Input side is a queue write port: in_data is taken at a clock edge with
// in_push high and in_full low. Job beats add into the open machine's sums
// as they are taken. A machine_last or schedule_last beat is queued to the back
// end, which evaluates the normal CDF of the closed machine and folds it into
// the running product; a close uses the shared bit-serial divider
// (72 + 61 + 13 x 34 steps), the 24-step square root and a 6-step reduction
// by ln2, though a zero variance or a saturated ratio skips some of these.
// Beats without close or end are not queued; the two-entry close queue
// lets job beats keep flowing while a close is worked on.
// Results come out of a one-entry output register: out_data is valid while
// out_empty is low and leaves on out_pop. A stalled reader holds the back end
// at its next schedule end; the input stalls once the close queue fills.
// cfg_data (deadline) is written on cfg_valid; cfg_ready is always high.
// Synchronous reset (rst_n low) clears sums, product to 1.0, count and queues.
`default_nettype none
module normal_cdf_service_level_top (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_push,
  input  ncsl_pkg::in_item_t   in_data,
  output logic                 in_full,
  output logic                 out_empty,
  input  wire logic            out_pop,
  output ncsl_pkg::out_item_t  out_data,
  input  wire logic            cfg_valid,
  input  wire logic [15:0]     cfg_data,
  output logic                 cfg_ready
);
  import ncsl_pkg::*;

  close_req_t q_wdata, q_head;
  logic       q_push, q_full, q_pop, q_empty;

  ncsl_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_data  (in_data),
    .in_full  (in_full),
    .cfg_valid(cfg_valid),
    .cfg_data (cfg_data),
    .cfg_ready(cfg_ready),
    .q_push   (q_push),
    .q_data   (q_wdata),
    .q_full   (q_full)
  );

  ncsl_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_data(q_wdata),
    .full     (q_full),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty)
  );

  ncsl_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_head   (q_head),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .out_data (out_data),
    .out_empty(out_empty),
    .out_pop  (out_pop)
  );

endmodule
`default_nettype wire

// File: rtl/ncsl_queue.sv
`default_nettype none
module ncsl_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  ncsl_pkg::close_req_t    push_data,
  output logic                    full,
  input  wire logic               pop,
  output ncsl_pkg::close_req_t    head,
  output logic                    empty
);
  import ncsl_pkg::*;

  close_req_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0]       wr_r, wr_nxt, rd_r, rd_nxt;
  logic [QPTR_W:0]         cnt_r, cnt_nxt;
  logic                    do_push, do_pop;

  assign full    = (cnt_r == (QPTR_W+1)'(QDEPTH));
  assign empty   = (cnt_r == '0);
  assign head    = mem_r[rd_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wr_nxt = (wr_r == QPTR_W'(QDEPTH-1)) ? '0 : wr_r + 1'b1;
    end
    if (do_pop) begin
      rd_nxt = (rd_r == QPTR_W'(QDEPTH-1)) ? '0 : rd_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
    if (do_push) begin
      mem_r[wr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

// File: rtl/ncsl_front.sv
`default_nettype none
module ncsl_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_push,
  input  ncsl_pkg::in_item_t    in_data,
  output logic                  in_full,
  input  wire logic             cfg_valid,
  input  wire logic [15:0]      cfg_data,
  output logic                  cfg_ready,
  output logic                  q_push,
  output ncsl_pkg::close_req_t  q_data,
  input  wire logic             q_full
);
  import ncsl_pkg::*;

  logic [15:0] deadline_r, deadline_nxt;
  logic [15:0] mean_r, mean_nxt, var_r, var_nxt;
  logic [15:0] mean_add, var_add;
  logic        accept, marker;

  assign in_full   = q_full;
  assign cfg_ready = 1'b1;
  assign accept    = in_push && !q_full;
  assign marker    = in_data.machine_last || in_data.schedule_last;

  assign mean_add = in_data.job_present ? mean_r + in_data.job_mean : mean_r;
  assign var_add  = in_data.job_present ? var_r + in_data.job_variance : var_r;

  assign q_push          = accept && marker;
  assign q_data.close    = in_data.machine_last;
  assign q_data.emit     = in_data.schedule_last;
  assign q_data.d        = {1'b0, deadline_r} - {1'b0, mean_add};
  assign q_data.var_sum  = var_add;

  always_comb begin
    deadline_nxt = cfg_valid ? cfg_data : deadline_r;
    mean_nxt     = mean_r;
    var_nxt      = var_r;
    if (accept) begin
      mean_nxt = marker ? '0 : mean_add;
      var_nxt  = marker ? '0 : var_add;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deadline_r <= '0;
      mean_r     <= '0;
      var_r      <= '0;
    end else begin
      deadline_r <= deadline_nxt;
      mean_r     <= mean_nxt;
      var_r      <= var_nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/ncsl_div.sv
`default_nettype none
module ncsl_div (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  ncsl_pkg::div_req_t req,
  output ncsl_pkg::div_rsp_t rsp
);
  import ncsl_pkg::*;

  logic [DIV_NW-1:0] sh_r, sh_nxt;
  logic [DIV_DW-1:0] rem_r, rem_nxt, den_r, den_nxt;
  logic [DIV_CW-1:0] cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt, done_r, done_nxt;
  logic [DIV_DW:0]   trial, diff;
  logic              ge;

  // restoring division, one quotient bit per cycle, quotient shifts in at the bottom
  assign trial = {rem_r, sh_r[DIV_NW-1]};
  assign ge    = trial >= {1'b0, den_r};
  assign diff  = trial - {1'b0, den_r};

  always_comb begin
    sh_nxt   = sh_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      sh_nxt   = req.num << (DIV_CW'(DIV_NW) - req.nbits);
      rem_nxt  = '0;
      den_nxt  = req.den;
      cnt_nxt  = req.nbits;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      sh_nxt  = {sh_r[DIV_NW-2:0], ge};
      rem_nxt = ge ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == DIV_CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    sh_r  <= sh_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    cnt_r <= cnt_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quo  = sh_r;

endmodule
`default_nettype wire

// File: rtl/ncsl_back.sv
`default_nettype none
module ncsl_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  ncsl_pkg::close_req_t  q_head,
  input  wire logic             q_empty,
  output logic                  q_pop,
  output ncsl_pkg::out_item_t   out_data,
  output logic                  out_empty,
  input  wire logic             out_pop
);
  import ncsl_pkg::*;

  back_state_t        state_r, state_nxt;
  close_req_t         job_r, job_nxt;
  logic [16:0]        level_r, level_nxt;
  logic [15:0]        count_r, count_nxt;
  logic               ov_r, ov_nxt;
  out_item_t          od_r, od_nxt;

  logic [63:0]        prod_r;
  logic [32:0]        mul_a;
  logic [30:0]        mul_b;

  logic [47:0]        sv_r, sv_nxt, sres_r, sres_nxt, sbit_r, sbit_nxt;
  logic [23:0]        xq_r, xq_nxt;
  logic [30:0]        t_r, t_nxt;
  logic signed [33:0] acc_r, acc_nxt;
  logic [2:0]         idx_r, idx_nxt;
  logic [6:0]         k_r, k_nxt;
  logic [29:0]        rr_r, rr_nxt;
  logic [30:0]        term_r, term_nxt;
  logic signed [33:0] sum_r, sum_nxt;
  logic [3:0]         n_r, n_nxt;
  logic [32:0]        e_r, e_nxt;
  logic [30:0]        phi_r, phi_nxt;
  logic [30:0]        p30_r, p30_nxt;

  div_req_t           dreq;
  div_rsp_t           drsp;

  logic [15:0]        ad;
  logic               d_neg;
  logic [63:0]        rnd30;
  logic [32:0]        mag;
  logic signed [33:0] acc_step;
  logic [48:0]        strial;
  logic [31:0]        den;
  logic [35:0]        u;
  logic [63:0]        eshift;
  logic [32:0]        epos;
  logic signed [34:0] pcalc;
  logic [17:0]        lp;
  logic [47:0]        ln2_sh;
  logic               kge;

  ncsl_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (dreq),
    .rsp  (drsp)
  );

  assign d_neg  = job_r.d[16];
  assign ad     = d_neg ? 16'(17'd0 - job_r.d) : job_r.d[15:0];
  assign rnd30  = (prod_r + (64'd1 << (WF-1))) >> WF;
  assign mag    = rnd30[32:0];
  assign strial = {1'b0, sres_r} + {1'b0, sbit_r};
  assign den    = 32'(ONE_Q30) + 32'((prod_r + (64'd1 << 19)) >> 20);
  assign u      = 36'((prod_r + (64'd1 << 10)) >> 11);
  assign epos   = sum_r[33] ? '0 : sum_r[32:0];
  // u / ln2 by compare and subtract of ln2 << idx, idx 5 down to 0 (k < 64)
  assign ln2_sh = 48'(LN2_Q30) << idx_r;
  assign kge    = sv_r >= ln2_sh;

  always_comb begin
    // signed mul_q30: magnitude rounded, sign applied afterwards
    acc_step = coef(idx_r) + (acc_r[33] ? (34'd0 - {1'b0, mag}) : {1'b0, mag});
    if (k_r == '0) begin
      eshift = {31'd0, epos};
    end else if (k_r >= 7'd62) begin
      eshift = '0;
    end else begin
      eshift = ({31'd0, epos} + (64'd1 << (k_r - 1'b1))) >> k_r;
    end
    pcalc = d_neg ? 35'(mag) : (35'(ONE_Q30) - 35'(mag));
    lp    = 18'((prod_r + 64'd32768) >> 16);
  end

  // one shared multiplier, product registered
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      B_CHK:   begin mul_a = 33'(ad);            mul_b = 31'(ad);      end
      B_DEN:   begin mul_a = 33'(COEF_B0);       mul_b = 31'(xq_r);    end
      B_PM:    begin
        mul_a = acc_r[33] ? 33'(34'd0 - acc_r) : acc_r[32:0];
        mul_b = t_r;
      end
      B_UM:    begin mul_a = 33'(xq_r);          mul_b = 31'(xq_r);    end
      B_EM:    begin mul_a = 33'(term_r);        mul_b = 31'(rr_r);    end
      B_PHM:   begin mul_a = e_r;                mul_b = 31'(INV_SQRT_2PI); end
      B_TLM:   begin mul_a = acc_r[32:0];        mul_b = phi_r;        end
      B_P16:   begin mul_a = 33'(level_r);       mul_b = 31'(to_q16(p30_r)); end
      default: begin mul_a = '0;                 mul_b = '0;           end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE:  if (!q_empty) state_nxt = q_head.close ? B_CHK : B_EMIT;
      B_CHK:   state_nxt = (job_r.var_sum == '0) ? B_P16 : B_DD;
      B_DD:    state_nxt = (prod_r >= {42'd0, job_r.var_sum, 6'd0}) ? B_DEN : B_QDIV;
      B_QDIV:  if (drsp.done) state_nxt = B_SQRT;
      B_SQRT:  if (sbit_r == 48'd1) state_nxt = B_DEN;
      B_DEN:   state_nxt = B_DEN2;
      B_DEN2:  state_nxt = B_TDIV;
      B_TDIV:  if (drsp.done) state_nxt = B_PM;
      B_PM:    state_nxt = B_PA;
      B_PA:    state_nxt = (idx_r == '0) ? B_UM : B_PM;
      B_UM:    state_nxt = B_UD;
      B_UD:    state_nxt = B_KDIV;
      B_KDIV:  if (idx_r == '0) state_nxt = B_EM;
      B_EM:    state_nxt = B_EA;
      B_EA:    state_nxt = B_ED;
      B_ED:    if (drsp.done) state_nxt = (n_r == 4'd13) ? B_ESH : B_EM;
      B_ESH:   state_nxt = B_PHM;
      B_PHM:   state_nxt = B_PHA;
      B_PHA:   state_nxt = B_TLM;
      B_TLM:   state_nxt = B_TLA;
      B_TLA:   state_nxt = B_P16;
      B_P16:   state_nxt = B_PROD;
      B_PROD:  state_nxt = job_r.emit ? B_EMIT : B_IDLE;
      B_EMIT:  if (!ov_r) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    job_nxt   = job_r;
    level_nxt = level_r;
    count_nxt = count_r;
    ov_nxt    = ov_r && !out_pop;
    od_nxt    = od_r;
    sv_nxt    = sv_r;
    sres_nxt  = sres_r;
    sbit_nxt  = sbit_r;
    xq_nxt    = xq_r;
    t_nxt     = t_r;
    acc_nxt   = acc_r;
    idx_nxt   = idx_r;
    k_nxt     = k_r;
    rr_nxt    = rr_r;
    term_nxt  = term_r;
    sum_nxt   = sum_r;
    n_nxt     = n_r;
    e_nxt     = e_r;
    phi_nxt   = phi_r;
    p30_nxt   = p30_r;
    q_pop     = 1'b0;
    dreq      = '0;
    case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          q_pop   = 1'b1;
          job_nxt = q_head;
        end
      end
      B_CHK: begin
        p30_nxt = d_neg ? '0 : ONE_Q30;
      end
      B_DD: begin
        if (prod_r >= {42'd0, job_r.var_sum, 6'd0}) begin
          xq_nxt = XQ_SAT;
        end else begin
          dreq.start = 1'b1;
          dreq.num   = {prod_r[31:0], 40'd0};
          dreq.den   = 32'(job_r.var_sum);
          dreq.nbits = 7'd72;
        end
      end
      B_QDIV: begin
        sv_nxt   = drsp.quo[47:0];
        sres_nxt = '0;
        sbit_nxt = 48'd1 << 46;
      end
      B_SQRT: begin
        // bit-pair integer square root, one step per cycle
        if ({1'b0, sv_r} >= strial) begin
          sv_nxt   = sv_r - strial[47:0];
          sres_nxt = (sres_r >> 1) + sbit_r;
        end else begin
          sres_nxt = sres_r >> 1;
        end
        sbit_nxt = sbit_r >> 2;
        if (sbit_r == 48'd1) xq_nxt = sres_nxt[23:0];
      end
      B_DEN2: begin
        dreq.start = 1'b1;
        dreq.num   = (72'd1 << 60) + 72'(den >> 1);
        dreq.den   = den;
        dreq.nbits = 7'd61;
      end
      B_TDIV: begin
        t_nxt   = drsp.quo[30:0];
        acc_nxt = coef(3'd5);
        idx_nxt = 3'd4;
      end
      B_PA: begin
        acc_nxt = acc_step;
        if (idx_r == '0) begin
          if (acc_step[33]) acc_nxt = '0;
        end else begin
          idx_nxt = idx_r - 1'b1;
        end
      end
      B_UD: begin
        sv_nxt  = 48'(u);
        k_nxt   = '0;
        idx_nxt = 3'd5;
      end
      B_KDIV: begin
        if (kge) begin
          sv_nxt = sv_r - ln2_sh;
          k_nxt  = k_r | (7'd1 << idx_r);
        end
        if (idx_r == '0) begin
          rr_nxt   = kge ? 30'(sv_r - ln2_sh) : sv_r[29:0];
          term_nxt = ONE_Q30;
          sum_nxt  = 34'(ONE_Q30);
          n_nxt    = 4'd1;
        end else begin
          idx_nxt = idx_r - 1'b1;
        end
      end
      B_EA: begin
        dreq.start = 1'b1;
        dreq.num   = 72'(mag) + 72'(n_r >> 1);
        dreq.den   = 32'(n_r);
        dreq.nbits = 7'd34;
      end
      B_ED: begin
        if (drsp.done) begin
          term_nxt = drsp.quo[30:0];
          sum_nxt  = n_r[0] ? sum_r - 34'(drsp.quo[30:0]) : sum_r + 34'(drsp.quo[30:0]);
          n_nxt    = n_r + 1'b1;
        end
      end
      B_ESH: begin
        // clamp at zero, then scale by 2^-k
        e_nxt = eshift[32:0];
      end
      B_PHA: begin
        phi_nxt = mag[30:0];
      end
      B_TLA: begin
        if (pcalc[34]) begin
          p30_nxt = '0;
        end else if (pcalc > 35'(ONE_Q30)) begin
          p30_nxt = ONE_Q30;
        end else begin
          p30_nxt = pcalc[30:0];
        end
      end
      B_PROD: begin
        level_nxt = (lp > 18'd65536) ? 17'd65536 : lp[16:0];
        if (count_r != 16'hFFFF) count_nxt = count_r + 1'b1;
      end
      B_EMIT: begin
        if (!ov_r) begin
          ov_nxt                  = 1'b1;
          od_nxt.service_level    = level_r;
          od_nxt.machines_counted = count_r;
          level_nxt               = 17'd65536;
          count_nxt               = '0;
        end
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      level_r <= 17'd65536;
      count_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      level_r <= level_nxt;
      count_r <= count_nxt;
      ov_r    <= ov_nxt;
    end
    prod_r <= 64'(mul_a) * 64'(mul_b);
    job_r  <= job_nxt;
    od_r   <= od_nxt;
    sv_r   <= sv_nxt;
    sres_r <= sres_nxt;
    sbit_r <= sbit_nxt;
    xq_r   <= xq_nxt;
    t_r    <= t_nxt;
    acc_r  <= acc_nxt;
    idx_r  <= idx_nxt;
    k_r    <= k_nxt;
    rr_r   <= rr_nxt;
    term_r <= term_nxt;
    sum_r  <= sum_nxt;
    n_r    <= n_nxt;
    e_r    <= e_nxt;
    phi_r  <= phi_nxt;
    p30_r  <= p30_nxt;
  end

  assign out_data  = od_r;
  assign out_empty = !ov_r;

endmodule
`default_nettype wire
